FILE: rtl/core/tccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants of the text console cursor and scroll engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OFFSET_W = 11;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int CHAR_W   = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [CHAR_W-1:0] CODE_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CODE_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR  = 8'h0D;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_SET   = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_SCRUB,
        ST_CLEAR
    } state_t;

endpackage

FILE: rtl/core/text_console_cursor_scroll_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Text console engine: cursor, line wrap, status-line scroll over a cell memory.
// ----------------------------------------------------------------------------
// A printable character, line feed, carriage return, NUL or set-cursor item that
// does not scroll is finished in the idle state. A read-cell item passes through a
// read state for the registered read data of the cell memory. A put that scrolls
// copies rows 2..ROWS-1 up one row, one cell per cycle, then clears the bottom row
// one cell per cycle. A clear-screen item clears every cell. After reset the block
// runs a clearing pass over all ROWS*COLUMNS cells (2000 at 80x25) with in_stall
// high; configuration writes are taken at any time. One result is produced per
// item, held in an output register with a one-entry skid behind it.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core
    import tccs_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // input items
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [6:0]          col_in,
    input  logic [4:0]          row_in,
    // results
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OFFSET_W-1:0] cursor_offset,
    output logic [CELL_W-1:0]   cell_value,
    output logic                scrolled,
    // attribute register
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ATTR_W-1:0]   cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int OFFW  = (AW > OFFSET_W) ? AW : OFFSET_W;

    localparam logic [AW-1:0] LAST_CELL    = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_START   = AW'(2 * COLUMNS);
    localparam logic [AW-1:0] BOTTOM_START = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] ROW_STRIDE   = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST     = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST     = RW'(ROWS - 1);

    state_t state_reg, state_next;

    logic [CW-1:0]     cursor_col_reg, cursor_col_next;
    logic [RW-1:0]     cursor_row_reg, cursor_row_next;
    logic [ATTR_W-1:0] text_attr_reg;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              copy_valid_reg, copy_valid_next;
    logic [AW-1:0]     copy_addr_reg, copy_addr_next;
    logic              read_ok_reg, read_ok_next;

    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [CELL_W-1:0]   out_cell_reg;
    logic                out_scrolled_reg;
    logic                skid_valid_reg;
    logic [OFFSET_W-1:0] skid_offset_reg;
    logic [CELL_W-1:0]   skid_cell_reg;
    logic                skid_scrolled_reg;

    logic              in_accept;
    action_t           act;
    logic              put_scroll;
    logic              last_cell;
    logic [AW-1:0]     cursor_addr;
    logic [AW-1:0]     read_addr_in;
    logic              in_range;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [CELL_W-1:0] rd_data;

    logic                done;
    logic [CELL_W-1:0]   done_cell;
    logic                done_scrolled;
    logic [OFFW-1:0]     offset_full;
    logic [OFFSET_W-1:0] done_offset;

    assign in_stall  = (state_reg != ST_IDLE) || skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign act       = action_t'(action);
    assign last_cell = (ptr_reg == LAST_CELL);
    assign cfg_ready = 1'b1;

    assign cursor_addr  = AW'(cursor_row_reg) * ROW_STRIDE + AW'(cursor_col_reg);
    assign read_addr_in = AW'(row_in) * ROW_STRIDE + AW'(col_in);
    assign in_range     = ({1'b0, col_in} < 8'(COLUMNS)) && ({2'b0, row_in} < 7'(ROWS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (act)
                        ACT_PUT:   state_next = put_scroll ? ST_COPY : ST_IDLE;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_READ:  state_next = ST_READ;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                if (last_cell)
                begin
                    state_next = ST_SCRUB;
                end
            end
            ST_SCRUB:
            begin
                if (!copy_valid_reg && last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        ptr_next        = ptr_reg;
        copy_valid_next = 1'b0;
        copy_addr_next  = copy_addr_reg;
        read_ok_next    = read_ok_reg;
        put_scroll      = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = '0;
        rd_addr         = ptr_reg;
        done            = 1'b0;
        done_cell       = '0;
        done_scrolled   = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                rd_addr = read_addr_in;
                if (in_accept)
                begin
                    case (act)
                        ACT_PUT:
                        begin
                            logic adv_row;
                            adv_row = 1'b0;
                            case (char_code)
                                CODE_LF:  adv_row = 1'b1;
                                CODE_CR:  cursor_col_next = '0;
                                CODE_NUL: adv_row = 1'b0;
                                default:
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = cursor_addr;
                                    wr_data = {text_attr_reg, char_code};
                                    if (cursor_col_reg == COL_LAST)
                                    begin
                                        cursor_col_next = '0;
                                        adv_row         = 1'b1;
                                    end
                                    else
                                    begin
                                        cursor_col_next = cursor_col_reg + CW'(1);
                                    end
                                end
                            endcase
                            if (adv_row)
                            begin
                                if (cursor_row_reg == ROW_LAST)
                                begin
                                    put_scroll = 1'b1;
                                end
                                else
                                begin
                                    cursor_row_next = cursor_row_reg + RW'(1);
                                end
                            end
                            if (put_scroll)
                            begin
                                ptr_next = COPY_START;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cursor_col_next = '0;
                            cursor_row_next = RW'(1);
                            ptr_next        = '0;
                        end
                        ACT_SET:
                        begin
                            cursor_col_next = ({1'b0, col_in} >= 8'(COLUMNS)) ?
                                              COL_LAST : CW'(col_in);
                            cursor_row_next = ({2'b0, row_in} >= 7'(ROWS)) ?
                                              ROW_LAST : RW'(row_in);
                            done            = 1'b1;
                        end
                        default:
                        begin
                            read_ok_next = in_range;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                done      = 1'b1;
                done_cell = read_ok_reg ? rd_data : '0;
            end
            ST_COPY:
            begin
                // read one row below, write it back one row up in the next cycle
                copy_valid_next = 1'b1;
                copy_addr_next  = ptr_reg - ROW_STRIDE;
                if (copy_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = copy_addr_reg;
                    wr_data = rd_data;
                end
                ptr_next = last_cell ? BOTTOM_START : ptr_reg + AW'(1);
            end
            ST_SCRUB:
            begin
                if (copy_valid_reg)
                begin
                    // drain the last copy before clearing the bottom row
                    wr_en   = 1'b1;
                    wr_addr = copy_addr_reg;
                    wr_data = rd_data;
                end
                else
                begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg + AW'(1);
                    if (last_cell)
                    begin
                        done          = 1'b1;
                        done_scrolled = 1'b1;
                    end
                end
            end
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + AW'(1);
                done     = last_cell;
            end
            default:
            begin
                ptr_next = '0;
            end
        endcase
    end

    assign offset_full = OFFW'(cursor_row_next) * OFFW'(COLUMNS) + OFFW'(cursor_col_next);
    assign done_offset = offset_full[OFFSET_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            text_attr_reg  <= ATTR_RESET;
            ptr_reg        <= '0;
            copy_valid_reg <= 1'b0;
            read_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            ptr_reg        <= ptr_next;
            copy_valid_reg <= copy_valid_next;
            read_ok_reg    <= read_ok_next;
            if (cfg_valid)
            begin
                text_attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= copy_addr_next;
    end

    // Output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= done;
            end
        end
        else if (done)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_offset_reg   <= skid_offset_reg;
                out_cell_reg     <= skid_cell_reg;
                out_scrolled_reg <= skid_scrolled_reg;
            end
            else if (done)
            begin
                out_offset_reg   <= done_offset;
                out_cell_reg     <= done_cell;
                out_scrolled_reg <= done_scrolled;
            end
        end
        else if (done)
        begin
            skid_offset_reg   <= done_offset;
            skid_cell_reg     <= done_cell;
            skid_scrolled_reg <= done_scrolled;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_offset = out_offset_reg;
    assign cell_value    = out_cell_reg;
    assign scrolled      = out_scrolled_reg;

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

FILE: rtl/core/tccs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/tccs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_checker
// Port-level assertions for the text console core, bound to the top level.
// ----------------------------------------------------------------------------
module tccs_checker
    import tccs_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [1:0]          action,
    input logic [6:0]          col_in,
    input logic [4:0]          row_in,
    input logic                out_valid,
    input logic                out_stall,
    input logic [OFFSET_W-1:0] cursor_offset,
    input logic [CELL_W-1:0]   cell_value,
    input logic                scrolled
);

    localparam int CELLS      = ROWS * COLUMNS;
    localparam bit SMALL      = (CELLS <= (1 << OFFSET_W));
    localparam int BOTTOM_OFF = (ROWS - 1) * COLUMNS;

    int                  exp_col;
    int                  exp_row;
    logic [OFFSET_W-1:0] exp_offset;

    assign exp_col    = (int'(col_in) >= COLUMNS) ? COLUMNS - 1 : int'(col_in);
    assign exp_row    = (int'(row_in) >= ROWS) ? ROWS - 1 : int'(row_in);
    assign exp_offset = OFFSET_W'(exp_row * COLUMNS + exp_col);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_offset)
                                   && $stable(cell_value) && $stable(scrolled))
        else $error("stalled result changed");

    // cursor stays on screen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !SMALL || (int'(cursor_offset) < CELLS))
        else $error("cursor offset outside the screen");

    // a scroll leaves the cursor on the bottom row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> !SMALL || (int'(cursor_offset) >= BOTTOM_OFF))
        else $error("scroll left cursor above bottom row");

    // set-cursor transfer shows the saturated position next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACT_SET) && (!out_valid || !out_stall)
        |=> out_valid && !scrolled && (cell_value == '0)
            && (cursor_offset == $past(exp_offset)))
        else $error("set cursor gave wrong result");

endmodule

bind text_console_cursor_scroll_core tccs_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccs_checker (.*);

FILE: sim/text_console_cursor_scroll_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core_tb
// Self-checking bench for the text console engine. A behavioral copy of the
// screen, cursor and attribute register predicts the result of every accepted
// transfer. Directed edge cases come first, then a back-pressure burst and
// several phases of random console traffic under different attributes. Both
// handshake sides idle at random, and results are compared field by field.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core_tb;
    import tccs_pkg::*;

    localparam int COLS  = COLUMNS_DEF;
    localparam int LINES = ROWS_DEF;
    localparam int CELLS = COLS * LINES;

    typedef struct {
        logic [OFFSET_W-1:0] offset;
        logic [CELL_W-1:0]   word;
        logic                scroll;
    } console_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          action;
    logic [CHAR_W-1:0]   char_code;
    logic [6:0]          col_in;
    logic [4:0]          row_in;
    logic                out_valid;
    logic                out_stall;
    logic [OFFSET_W-1:0] cursor_offset;
    logic [CELL_W-1:0]   cell_value;
    logic                scrolled;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ATTR_W-1:0]   cfg_data;

    // predicted console state
    logic [CELL_W-1:0]   screen [CELLS];
    logic [6:0]          cur_col;
    logic [4:0]          cur_row;
    logic [ATTR_W-1:0]   attr_model;

    console_result_t     due_results [$];
    int                  fault_count = 0;
    int                  hold_cycles = 0;
    bit                  calm = 1'b0;

    text_console_cursor_scroll_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .char_code     (char_code),
        .col_in        (col_in),
        .row_in        (row_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_offset (cursor_offset),
        .cell_value    (cell_value),
        .scrolled      (scrolled),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] rnd_char();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [6:0] rnd_col();
        return 7'($urandom_range(127));
    endfunction

    function automatic logic [4:0] rnd_row();
        return 5'($urandom_range(31));
    endfunction

    function automatic console_result_t advance_console(action_t act, logic [7:0] ch,
            logic [6:0] col, logic [4:0] row);
        console_result_t r;
        r.word   = '0;
        r.scroll = 1'b0;
        case (act)
            ACT_PUT:
            begin
                if (ch == CODE_LF)
                    cur_row = cur_row + 5'd1;
                else if (ch == CODE_CR)
                    cur_col = '0;
                else if (ch != CODE_NUL)
                begin
                    screen[cur_row * COLS + cur_col] = {attr_model, ch};
                    cur_col = cur_col + 7'd1;
                end
                // column can only reach COLS, so a wrap is always one row
                if (cur_col >= COLS)
                begin
                    cur_col = '0;
                    cur_row = cur_row + 5'd1;
                end
                // keep row 0 as status line, shift the rest up, blank the bottom
                if (cur_row >= LINES)
                begin
                    for (int i = COLS; i < CELLS - COLS; i++)
                        screen[i] = screen[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        screen[i] = '0;
                    cur_row  = 5'(LINES - 1);
                    r.scroll = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen[i] = '0;
                cur_col = '0;
                cur_row = 5'd1;
            end
            ACT_SET:
            begin
                cur_col = (col >= COLS) ? 7'(COLS - 1) : col;
                cur_row = (row >= LINES) ? 5'(LINES - 1) : row;
            end
            ACT_READ:
            begin
                if (col < COLS && row < LINES)
                    r.word = screen[row * COLS + col];
            end
        endcase
        r.offset = OFFSET_W'(cur_row * COLS + cur_col);
        return r;
    endfunction

    function automatic void note_fault(string what, logic [15:0] want_v, logic [15:0] got_v);
        if (fault_count < 10)
            $display("mismatch on %s at %0t: expected %h, actual %h", what, $realtime,
                     want_v, got_v);
        fault_count++;
    endfunction

    // Offer one item and hold it until the block takes it; valid stays high on return.
    task automatic send_item(action_t act, logic [7:0] ch, logic [6:0] col, logic [4:0] row);
        if (!calm)
            while ($urandom_range(99) < 7)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid  <= 1'b1;
        action    <= act;
        char_code <= ch;
        col_in    <= col;
        row_in    <= row;
        do
            @(posedge clk);
        while (in_stall);
        due_results.push_back(advance_console(act, ch, col, row));
    endtask

    // Drop valid and wait until every predicted result has been seen.
    task automatic drain();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_attr(logic [ATTR_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        attr_model = value;
    endtask

    task automatic test_reset_contents();
        send_item(ACT_READ, rnd_char(), 7'd0, 5'd0);
        send_item(ACT_READ, rnd_char(), 7'(COLS - 1), 5'(LINES - 1));
        send_item(ACT_READ, rnd_char(), 7'(COLS), 5'd0);
        send_item(ACT_READ, rnd_char(), 7'd0, 5'(LINES));
        send_item(ACT_READ, rnd_char(), 7'd127, 5'd31);
    endtask

    // Runs under the reset attribute: printable, NUL, CR and LF codes.
    task automatic test_put_codes();
        send_item(ACT_PUT, 8'h41, rnd_col(), rnd_row());
        send_item(ACT_PUT, 8'hFF, rnd_col(), rnd_row());
        send_item(ACT_PUT, CODE_NUL, rnd_col(), rnd_row());
        send_item(ACT_PUT, 8'h01, rnd_col(), rnd_row());
        send_item(ACT_PUT, CODE_CR, rnd_col(), rnd_row());
        send_item(ACT_PUT, CODE_LF, rnd_col(), rnd_row());
        send_item(ACT_READ, rnd_char(), 7'd0, 5'd0);
        send_item(ACT_READ, rnd_char(), 7'd1, 5'd0);
        send_item(ACT_READ, rnd_char(), 7'd2, 5'd0);
    endtask

    task automatic test_wrap_and_scroll();
        write_attr(8'hFF);
        // saturating set lands on the last cell, the put there wraps and scrolls
        send_item(ACT_SET, rnd_char(), 7'd127, 5'd31);
        send_item(ACT_PUT, 8'h80, rnd_col(), rnd_row());
        send_item(ACT_READ, rnd_char(), 7'(COLS - 1), 5'(LINES - 2));
        send_item(ACT_READ, rnd_char(), 7'(COLS - 1), 5'(LINES - 1));
        send_item(ACT_SET, rnd_char(), 7'd5, 5'(LINES - 1));
        send_item(ACT_PUT, CODE_LF, rnd_col(), rnd_row());
        send_item(ACT_READ, rnd_char(), 7'd0, 5'd0);
    endtask

    task automatic test_clear_screen();
        write_attr(8'h00);
        send_item(ACT_PUT, 8'h55, rnd_col(), rnd_row());
        send_item(ACT_CLEAR, rnd_char(), rnd_col(), rnd_row());
        send_item(ACT_READ, rnd_char(), 7'd0, 5'd0);
        send_item(ACT_PUT, 8'h7F, rnd_col(), rnd_row());
        send_item(ACT_READ, rnd_char(), 7'd0, 5'd1);
    endtask

    // Hold the result side off while items keep coming so the input stalls.
    task automatic test_backpressure();
        calm = 1'b1;
        hold_cycles = 64;
        for (int k = 0; k < 30; k++)
            send_item(ACT_PUT, 8'(8'h21 + k), rnd_col(), rnd_row());
        calm = 1'b0;
    endtask

    task automatic test_random_traffic(int count, logic [ATTR_W-1:0] attr_value, bit quiet);
        int         pick;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] row;
        write_attr(attr_value);
        calm = quiet;
        repeat (count)
        begin
            pick = $urandom_range(99);
            ch   = rnd_char();
            col  = rnd_col();
            row  = rnd_row();
            if (pick < 70)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                    ch = CODE_LF;
                else if (pick < 9)
                    ch = CODE_CR;
                else if (pick < 11)
                    ch = CODE_NUL;
                send_item(ACT_PUT, ch, col, row);
            end
            else if (pick < 78)
            begin
                // favor the bottom rows so that scrolls come often
                if ($urandom_range(99) < 70)
                    col = 7'($urandom_range(COLS - 1));
                if ($urandom_range(99) < 60)
                    row = 5'($urandom_range(LINES - 1, LINES - 5));
                send_item(ACT_SET, ch, col, row);
            end
            else if (pick < 99)
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        row = cur_row;
                        col = 7'($urandom_range(COLS - 1));
                    end
                    1:
                    begin
                        row = 5'($urandom_range(LINES - 1));
                        col = 7'($urandom_range(COLS - 1));
                    end
                    default:
                        ;
                endcase
                send_item(ACT_READ, ch, col, row);
            end
            else
                send_item(ACT_CLEAR, ch, col, row);
        end
        calm = 1'b0;
    endtask

    // result side: random stalls, or a counted hold-off when one is requested
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 7);
        end
    end

    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
                note_fault("unexpected result offset", '0, 16'(cursor_offset));
            else
            begin
                want = due_results.pop_front();
                if (cursor_offset !== want.offset)
                    note_fault("cursor_offset", 16'(want.offset), 16'(cursor_offset));
                if (cell_value !== want.word)
                    note_fault("cell_value", want.word, cell_value);
                if (scrolled !== want.scroll)
                    note_fault("scrolled", 16'(want.scroll), 16'(scrolled));
            end
        end
    end

    initial
    begin
        #(50_000_000);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        action    <= ACT_PUT;
        char_code <= '0;
        col_in    <= '0;
        row_in    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        for (int i = 0; i < CELLS; i++)
            screen[i] = '0;
        cur_col    = '0;
        cur_row    = '0;
        attr_model = ATTR_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_put_codes();
        test_wrap_and_scroll();
        test_clear_screen();
        test_backpressure();
        test_random_traffic(320, 8'h00, 1'b0);
        test_random_traffic(320, 8'hFF, 1'b0);
        test_random_traffic(300, rnd_char(), 1'b1);
        test_random_traffic(320, rnd_char(), 1'b0);

        drain();
        repeat (20) @(posedge clk);
        if (fault_count == 0 && due_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
